// ===== src/soc_pkg.sv =====
// Shared types and constants for the subsequence occurrence counter.
package soc_pkg;
  localparam int MaxPattern = 16;
  localparam int CountBits = 48;
  localparam int LenBits = $clog2(MaxPattern + 1);
  localparam int IdxBits = (MaxPattern > 1) ? $clog2(MaxPattern) : 1;
  localparam int QDepth = 2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] value;
  } req_t;

  localparam logic [CountBits-1:0] CountMax = '1;

  // IEEE double equality on bit patterns
  function automatic logic dbl_eq(input logic [63:0] a, input logic [63:0] b);
    logic a_nan;
    logic b_nan;
    logic both_zero;
    a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
    b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
    both_zero = (a[62:0] == '0) && (b[62:0] == '0);
    return !a_nan && !b_nan && ((a == b) || both_zero);
  endfunction
endpackage

// ===== src/soc_front.sv =====
// Front end: accepts requests and queues them for the counter row.
module soc_front import soc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] op,
  input  logic [63:0] value,
  input  logic       valid,
  output logic       ready,
  output req_t       q_req,
  output logic       q_valid,
  input  logic       q_ready
);
  req_t             mem [QDepth];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             push;
  logic             pop;

  assign ready   = (fill != 2'(QDepth));
  assign push    = valid && ready;
  assign q_valid = (fill != 2'd0);
  assign pop     = q_valid && q_ready;
  assign q_req   = mem[rd_ptr];

  // Store incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{op: op_t'(op), value: value};
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== src/soc_back.sv =====
// Back end: pattern store, counter row and result register.
module soc_back import soc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  req_t                 q_req,
  input  logic                 q_valid,
  output logic                 q_ready,
  output logic [CountBits-1:0] count,
  output logic                 pattern_overflow,
  output logic                 out_valid,
  input  logic                 out_ready
);
  logic [63:0]          pat [MaxPattern];
  logic [CountBits-1:0] ctr [MaxPattern];
  logic [LenBits-1:0]   plen;
  logic                 ovf;
  logic                 take;
  logic [CountBits-1:0] final_cnt;

  // An end request needs the result slot free or draining
  assign q_ready = (q_req.op != OP_END) || !out_valid || out_ready;
  assign take    = q_valid && q_ready;
  assign final_cnt = (plen == '0) ? CountBits'(1) : ctr[IdxBits'(plen - LenBits'(1))];

  // Append pattern elements
  always_ff @(posedge clk) begin
    if (take && q_req.op == OP_APPEND && plen < LenBits'(MaxPattern)) begin
      pat[IdxBits'(plen)] <= q_req.value;
    end
  end

  // Update control state and counter row
  always_ff @(posedge clk) begin
    if (rst) begin
      plen <= '0;
      ovf  <= 1'b0;
      for (int j = 0; j < MaxPattern; j++) ctr[j] <= '0;
    end else if (take) begin
      case (q_req.op)
        OP_CLEAR: begin
          plen <= '0;
          ovf  <= 1'b0;
          for (int j = 0; j < MaxPattern; j++) ctr[j] <= '0;
        end
        OP_APPEND: begin
          if (plen < LenBits'(MaxPattern)) plen <= plen + LenBits'(1);
          else ovf <= 1'b1;
          for (int j = 0; j < MaxPattern; j++) ctr[j] <= '0;
        end
        OP_TEXT: begin
          for (int j = 0; j < MaxPattern; j++) begin
            if (LenBits'(j) < plen && dbl_eq(q_req.value, pat[j])) begin
              logic [CountBits-1:0] prev;
              logic [CountBits:0]   s;
              prev = (j == 0) ? CountBits'(1) : ctr[(j == 0) ? 0 : j - 1];
              s = {1'b0, ctr[j]} + {1'b0, prev};
              ctr[j] <= s[CountBits] ? CountMax : s[CountBits-1:0];
            end
          end
        end
        default: begin
          for (int j = 0; j < MaxPattern; j++) ctr[j] <= '0;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && q_req.op == OP_END) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && q_req.op == OP_END) begin
      count            <= final_cnt;
      pattern_overflow <= ovf;
    end
  end
endmodule

// ===== src/subsequence_occurrence_count.sv =====
// Top level of the subsequence occurrence counter.
// Input channel (in_valid/in_ready, op, value) carries requests: clear,
// append a pattern element, a text element, or end of text.
// Output channel (out_valid/out_ready, count, pattern_overflow) carries one
// result for each end-of-text request: the number of in-order, not
// necessarily consecutive, occurrences of the pattern, saturating at all ones.
// Throughput: one request per cycle while no end request waits on a stalled
// result; all counters of the row update at once from their old values in the back end.
// An end request passes through the two-entry request queue; its result is then
// written into the result register.
// When the receiver stalls, the result register holds; text requests ahead of
// the next end request keep flowing, that end request waits at the head of the
// queue, and once the two queue entries are full the input stalls.
// Reset empties the pattern, zeroes the counters and the overflow flag,
// and drops queued requests and any pending result.
module subsequence_occurrence_count import soc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           op,
  input  logic [63:0]          value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CountBits-1:0] count,
  output logic                 pattern_overflow
);
  req_t q_req;
  logic q_valid;
  logic q_ready;

  soc_front u_front (
    .clk(clk), .rst(rst), .op(op), .value(value), .valid(in_valid),
    .ready(in_ready), .q_req(q_req), .q_valid(q_valid), .q_ready(q_ready)
  );

  soc_back u_back (
    .clk(clk), .rst(rst), .q_req(q_req), .q_valid(q_valid), .q_ready(q_ready),
    .count(count), .pattern_overflow(pattern_overflow),
    .out_valid(out_valid), .out_ready(out_ready)
  );
endmodule

// ===== src/soc_checker.sv =====
// Port-level checks for the subsequence occurrence counter.
module soc_checker import soc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic [1:0]           op,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CountBits-1:0] count,
  input logic                 pattern_overflow
);
  // A result does not rise straight after reset
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(rst, 2))
    else $error("result without request");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count))
    else $error("result changed while stalled");

  // Result idle after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // Empty pattern after clear reports one
  a_clear: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && op == OP_CLEAR ##1 in_valid && in_ready && op == OP_END
      && !out_valid ##2 1'b1 |-> out_valid && count == CountBits'(1) && !pattern_overflow)
    else $error("empty pattern count wrong");
endmodule

bind subsequence_occurrence_count soc_checker u_soc_checker (.*);

// ===== bench/tb_top.sv =====
// Testbench for the subsequence occurrence counter: directed table, random requests, checks.
`timescale 1ns / 1ps
module tb_top;
  import soc_pkg::*;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           op;
  logic [63:0]          value;
  logic                 out_valid;
  logic                 out_ready;
  logic [CountBits-1:0] count;
  logic                 pattern_overflow;

  subsequence_occurrence_count i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .op(op), .value(value),
    .out_valid(out_valid), .out_ready(out_ready), .count(count),
    .pattern_overflow(pattern_overflow)
  );

  typedef struct {
    logic [CountBits-1:0] cnt;
    logic                 ovf;
  } tally_t;

  // predictor state
  logic [63:0]          pat_mem [MaxPattern];
  int                   pat_len;
  logic [CountBits-1:0] row [MaxPattern];
  logic                 ovf_flag;
  tally_t               tally_q[$];

  int mismatches;
  int n_sent;
  int n_ends;
  int n_results;
  bit quiet;
  bit hold_off;
  int long_stall;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic fp_equal(logic [63:0] a, logic [63:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = (a[62:52] == 11'h7ff) && (a[51:0] != 52'd0);
    b_nan = (b[62:52] == 11'h7ff) && (b[51:0] != 52'd0);
    if (a_nan || b_nan) return 1'b0;
    if (a[62:0] == 63'd0 && b[62:0] == 63'd0) return 1'b1;
    return a == b;
  endfunction

  function automatic logic [CountBits-1:0] add_sat(logic [CountBits-1:0] a,
                                                   logic [CountBits-1:0] b);
    logic [CountBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountBits] ? CountMax : s[CountBits-1:0];
  endfunction

  task automatic clear_row();
    for (int j = 0; j < MaxPattern; j++) row[j] = '0;
  endtask

  // advance the predicted state by one request
  task automatic predict_request(logic [1:0] o, logic [63:0] v);
    tally_t t;
    case (op_t'(o))
      OP_CLEAR: begin
        pat_len = 0;
        ovf_flag = 1'b0;
        clear_row();
      end
      OP_APPEND: begin
        if (pat_len < MaxPattern) begin
          pat_mem[pat_len] = v;
          pat_len++;
        end else begin
          ovf_flag = 1'b1;
        end
        clear_row();
      end
      OP_TEXT: begin
        for (int j = pat_len; j >= 1; j--) begin
          if (fp_equal(v, pat_mem[j-1]))
            row[j-1] = add_sat(row[j-1], (j == 1) ? CountBits'(1) : row[j-2]);
        end
      end
      default: begin
        t.cnt = (pat_len == 0) ? CountBits'(1) : row[pat_len-1];
        t.ovf = ovf_flag;
        tally_q.push_back(t);
        clear_row();
      end
    endcase
  endtask

  // offer one request and hold it until accepted
  task automatic send(logic [1:0] o, logic [63:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(o, v);
    n_sent++;
    if (op_t'(o) == OP_END) n_ends++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // check results against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (tally_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result count=%h", count);
      end else begin
        if (count !== tally_q[0].cnt || pattern_overflow !== tally_q[0].ovf) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: expected count=%h ovf=%b, got count=%h ovf=%b",
                     tally_q[0].cnt, tally_q[0].ovf, count, pattern_overflow);
        end
        void'(tally_q.pop_front());
      end
    end
  end

  // receiver stalls: random bursts, plus one long hold-off
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        long_stall = 0;
        while (long_stall < 60) begin
          @(posedge clk);
          long_stall++;
        end
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // directed table; expected count given only where obvious (-1 = use predictor)
  typedef struct {
    logic [1:0]  o;
    logic [63:0] v;
    longint      want;
  } row_t;

  localparam logic [63:0] PosZero = 64'h0000000000000000;
  localparam logic [63:0] NegZero = 64'h8000000000000000;
  localparam logic [63:0] QNan    = 64'h7ff8000000000000;
  localparam logic [63:0] One     = 64'h3ff0000000000000;
  localparam logic [63:0] AllOnes = 64'hffffffffffffffff;

  row_t plan[$];

  function automatic logic [63:0] pick_value(int pool);
    case ($urandom_range(0, 7))
      0: return PosZero;
      1: return NegZero;
      2: return QNan;
      3: return {$urandom, $urandom};
      default: return 64'h4000000000000000 | 64'($urandom_range(0, pool));
    endcase
  endfunction

  initial begin
    int plen;
    int tlen;
    int pool;
    logic [63:0] v;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_CLEAR;
    value = '0;
    mismatches = 0;
    n_sent = 0;
    n_ends = 0;
    n_results = 0;
    quiet = 1'b0;
    hold_off = 1'b0;
    pat_len = 0;
    ovf_flag = 1'b0;
    clear_row();
    for (int j = 0; j < MaxPattern; j++) pat_mem[j] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pattern, zero signs, NaN, extremes, clear
    plan = '{
      '{OP_END,    '0,      1},
      '{OP_TEXT,   AllOnes, -1},
      '{OP_END,    '0,      1},
      '{OP_APPEND, PosZero, -1},
      '{OP_TEXT,   NegZero, -1},
      '{OP_TEXT,   PosZero, -1},
      '{OP_END,    '0,      2},
      '{OP_CLEAR,  '0,      -1},
      '{OP_APPEND, QNan,    -1},
      '{OP_TEXT,   QNan,    -1},
      '{OP_END,    '0,      0},
      '{OP_CLEAR,  '0,      -1},
      '{OP_APPEND, AllOnes, -1},
      '{OP_APPEND, One,     -1},
      '{OP_TEXT,   One,     -1},
      '{OP_TEXT,   AllOnes, -1},
      '{OP_TEXT,   One,     -1},
      '{OP_END,    '0,      -1},
      '{OP_CLEAR,  '0,      -1},
      '{OP_END,    '0,      1}
    };
    foreach (plan[i]) begin
      if (plan[i].want >= 0 && (pat_len == 0 ? 1 : row[pat_len-1]) != plan[i].want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: directed row %0d expected count=%0d, predictor gives %0d",
                   i, plan[i].want, (pat_len == 0 ? 1 : row[pat_len-1]));
      end
      send(plan[i].o, plan[i].v);
    end

    // fill beyond capacity, then saturate with a long run of equal elements
    for (int k = 0; k < MaxPattern + 2; k++) send(OP_APPEND, One);
    for (int k = 0; k < 200; k++) send(OP_TEXT, One);
    send(OP_END, '0);
    send(OP_CLEAR, '0);
    send(OP_APPEND, One);
    send(OP_APPEND, One);
    for (int k = 0; k < 48; k++) send(OP_TEXT, One);
    send(OP_END, '0);

    // long receiver hold-off while requests keep coming
    hold_off = 1'b1;
    for (int k = 0; k < 30; k++) send(($urandom_range(0, 1) != 0) ? OP_END : OP_TEXT, One);
    // sender pause until all results are in
    go_idle();
    while (tally_q.size() != 0) @(posedge clk);

    // random well-formed sequences with some noise
    while (n_sent < 1800) begin
      if (n_sent > 1550) quiet = 1'b1;
      pool = $urandom_range(1, 4);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(MaxPattern - 1, MaxPattern + 3)
                                         : $urandom_range(0, 5);
      send(OP_CLEAR, {$urandom, $urandom});
      for (int k = 0; k < plen; k++) send(OP_APPEND, pick_value(pool));
      for (int r = 0; r < $urandom_range(1, 3); r++) begin
        tlen = $urandom_range(0, 25);
        for (int k = 0; k < tlen; k++) begin
          v = (pat_len > 0 && $urandom_range(0, 2) != 0) ?
              pat_mem[$urandom_range(0, pat_len - 1)] : pick_value(pool);
          if ($urandom_range(0, 1) != 0) v[63] = v[62:0] == 63'd0 ? ~v[63] : v[63];
          send(OP_TEXT, v);
        end
        send(OP_END, {$urandom, $urandom});
      end
    end
    go_idle();

    while (tally_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d requests, %0d end markers, %0d results checked.",
             n_sent, n_ends, n_results);
    $display("Covered empty and full patterns, signed zeros, NaN, saturation and stalls.");
    if (mismatches == 0 && tally_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches counted", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/soc_pkg.sv
src/soc_front.sv
src/soc_back.sv
src/subsequence_occurrence_count.sv
src/soc_checker.sv
bench/tb_top.sv
